// ===== rtl/core/sdspi_pkg.sv =====
package sdspi_pkg;

    localparam int unsigned PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_CMD   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ARG   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_CRC   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_FILL  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_R1    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_BUSY  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_R2A   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_R2B   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_TRAIL = 4'd9;

    localparam logic       OP_START    = 1'b0;
    localparam logic       OP_EXCHANGE = 1'b1;

    localparam logic [1:0] RESP_R1  = 2'd1;
    localparam logic [1:0] RESP_R1B = 2'd2;
    localparam logic [1:0] RESP_R2  = 2'd3;

    localparam logic [7:0]  CMD_PREFIX    = 8'h40;
    localparam logic [7:0]  CRC_CMD0      = 8'h95;
    localparam logic [7:0]  FILL_BYTE     = 8'hFF;
    localparam logic [7:0]  POLL_LIMIT_RST = 8'd100;
    localparam logic [15:0] R1_PREFIX     = 16'hFF00;
    localparam logic [15:0] RESP_NONE     = 16'hFFFF;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  cmd_index;
        logic [31:0] argument;
        logic [1:0]  response_type;
        logic        keep_cs_low;
        logic [7:0]  miso_byte;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [2:0]         byte_count;
        logic [7:0]         poll_count;
        logic [5:0]         idx;
        logic [31:0]        arg;
        logic [1:0]         rtype;
        logic               keep;
        logic [15:0]        resp;
        logic               cs;
    } seq_state_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  mosi_byte;
        logic        cs_level;
        logic        done_res;
        logic [15:0] response;
    } result_t;

endpackage

// ===== rtl/core/sdspi_step.sv =====
module sdspi_step (
    input  sdspi_pkg::item_t      item,
    input  sdspi_pkg::seq_state_t cur,
    input  logic [7:0]            poll_limit,
    output sdspi_pkg::seq_state_t nxt,
    output sdspi_pkg::result_t    res
);

    logic       send;
    logic       done;
    logic [7:0] mosi;
    logic       limit_hit;

    assign limit_hit = (cur.poll_count >= poll_limit);

    always_comb begin
        nxt  = cur;
        send = 1'b1;
        done = 1'b0;
        mosi = sdspi_pkg::FILL_BYTE;

        if (item.opcode == sdspi_pkg::OP_START) begin
            nxt.idx        = item.cmd_index;
            nxt.arg        = item.argument;
            nxt.rtype      = item.response_type;
            nxt.keep       = item.keep_cs_low;
            nxt.byte_count = 3'd0;
            nxt.poll_count = 8'd0;
            nxt.resp       = sdspi_pkg::RESP_NONE;
            nxt.cs         = 1'b0;
            nxt.phase      = sdspi_pkg::PH_CMD;
            mosi           = sdspi_pkg::CMD_PREFIX | {2'b00, item.cmd_index};
        end else begin
            case (cur.phase)
                sdspi_pkg::PH_CMD: begin
                    nxt.byte_count = 3'd0;
                    nxt.phase      = sdspi_pkg::PH_ARG;
                    mosi           = cur.arg[31:24];
                end
                sdspi_pkg::PH_ARG: begin
                    nxt.byte_count = cur.byte_count + 3'd1;
                    case (cur.byte_count)
                        3'd0: mosi = cur.arg[23:16];
                        3'd1: mosi = cur.arg[15:8];
                        3'd2: mosi = cur.arg[7:0];
                        default: begin
                            nxt.byte_count = cur.byte_count;
                            nxt.phase      = sdspi_pkg::PH_CRC;
                            mosi = (cur.idx == 6'd0) ? sdspi_pkg::CRC_CMD0
                                                     : sdspi_pkg::FILL_BYTE;
                        end
                    endcase
                end
                sdspi_pkg::PH_CRC: begin
                    nxt.phase = sdspi_pkg::PH_FILL;
                end
                sdspi_pkg::PH_FILL: begin
                    if (cur.rtype == sdspi_pkg::RESP_R2) begin
                        nxt.phase = sdspi_pkg::PH_R2A;
                    end else begin
                        nxt.poll_count = 8'd1;
                        nxt.phase      = sdspi_pkg::PH_R1;
                    end
                end
                sdspi_pkg::PH_R1: begin
                    if (item.miso_byte != 8'hFF || limit_hit) begin
                        nxt.resp = (item.miso_byte != 8'hFF)
                                 ? (sdspi_pkg::R1_PREFIX | {8'h00, item.miso_byte})
                                 : sdspi_pkg::RESP_NONE;
                        // R1b goes on to the busy wait, others wrap up
                        if (cur.rtype == sdspi_pkg::RESP_R1B) begin
                            nxt.poll_count = 8'd1;
                            nxt.phase      = sdspi_pkg::PH_BUSY;
                        end else begin
                            nxt.cs    = cur.cs | ~cur.keep;
                            nxt.phase = sdspi_pkg::PH_TRAIL;
                        end
                    end else begin
                        nxt.poll_count = cur.poll_count + 8'd1;
                    end
                end
                sdspi_pkg::PH_BUSY: begin
                    if (item.miso_byte != 8'h00 || limit_hit) begin
                        nxt.cs    = cur.cs | ~cur.keep;
                        nxt.phase = sdspi_pkg::PH_TRAIL;
                    end else begin
                        nxt.poll_count = cur.poll_count + 8'd1;
                    end
                end
                sdspi_pkg::PH_R2A: begin
                    nxt.resp  = {item.miso_byte, 8'h00};
                    nxt.phase = sdspi_pkg::PH_R2B;
                end
                sdspi_pkg::PH_R2B: begin
                    nxt.resp  = {cur.resp[15:8], cur.resp[7:0] | item.miso_byte};
                    nxt.cs    = cur.cs | ~cur.keep;
                    nxt.phase = sdspi_pkg::PH_TRAIL;
                end
                sdspi_pkg::PH_TRAIL: begin
                    nxt.phase = sdspi_pkg::PH_IDLE;
                    send      = 1'b0;
                    done      = 1'b1;
                end
                default: begin
                    // idle or unused code: drop the request
                    nxt.phase = sdspi_pkg::PH_IDLE;
                    send      = 1'b0;
                end
            endcase
        end

        res.send_valid = send;
        res.mosi_byte  = send ? mosi : 8'h00;
        res.cs_level   = nxt.cs;
        res.done_res   = done;
        res.response   = done ? nxt.resp : 16'h0000;
    end

endmodule

// ===== rtl/core/sd_spi_command_sequencer_core.sv =====
// Path: an accepted request is captured in the input register, then its result in the
// result register, which drives m_tvalid; while the output stalls, the request waits.
// Throughput: one request per cycle unless m_tready stalls; state updates in a single step.
// Reset: aresetn low at a rising edge clears both stages, returns the sequencer to idle
// with chip select released, and sets poll_limit to 100.
module sd_spi_command_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        poll_limit_we,
    input  logic [7:0]  poll_limit_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] cmd_index, [37:6] argument, [39:38] response_type,
    // [40] keep_cs_low, [48:41] miso_byte, [55:49] zero
    input  logic [55:0] s_tdata,
    // [0] opcode
    input  logic [0:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] mosi_byte, [8] cs_level, [24:9] response, [31:25] zero
    output logic [31:0] m_tdata,
    // [0] send_valid, [1] done_res
    output logic [1:0]  m_tuser
);

    logic                  in_valid_reg;
    sdspi_pkg::item_t      in_item_reg;
    sdspi_pkg::seq_state_t state_reg;
    sdspi_pkg::seq_state_t state_next;
    sdspi_pkg::result_t    res_next;
    sdspi_pkg::result_t    res_reg;
    logic                  out_valid_reg;
    logic [7:0]            poll_limit_reg;
    logic                  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_limit_reg <= sdspi_pkg::POLL_LIMIT_RST;
        end else if (poll_limit_we) begin
            poll_limit_reg <= poll_limit_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.opcode        <= s_tuser[0];
            in_item_reg.cmd_index     <= s_tdata[5:0];
            in_item_reg.argument      <= s_tdata[37:6];
            in_item_reg.response_type <= s_tdata[39:38];
            in_item_reg.keep_cs_low   <= s_tdata[40];
            in_item_reg.miso_byte     <= s_tdata[48:41];
        end
    end

    sdspi_step u_step (
        .item       (in_item_reg),
        .cur        (state_reg),
        .poll_limit (poll_limit_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= sdspi_pkg::PH_IDLE;
            state_reg.byte_count <= 3'd0;
            state_reg.poll_count <= 8'd0;
            state_reg.idx        <= 6'd0;
            state_reg.arg        <= 32'd0;
            state_reg.rtype      <= sdspi_pkg::RESP_R1;
            state_reg.keep       <= 1'b0;
            state_reg.resp       <= sdspi_pkg::RESP_NONE;
            state_reg.cs         <= 1'b1;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.response, res_reg.cs_level, res_reg.mosi_byte};
    assign m_tuser  = {res_reg.done_res, res_reg.send_valid};

    a_done_no_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("done result also asks for a byte exchange");

    a_start_asserts_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_item_reg.opcode == sdspi_pkg::OP_START) |=>
            !state_reg.cs && (state_reg.phase == sdspi_pkg::PH_CMD))
        else $error("start request did not assert chip select");

    a_trail_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_item_reg.opcode == sdspi_pkg::OP_EXCHANGE)
            && (state_reg.phase == sdspi_pkg::PH_TRAIL) |=>
            (state_reg.phase == sdspi_pkg::PH_IDLE) && m_tuser[1])
        else $error("trailing exchange did not finish the sequence");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("sequencer state moved without a request");

endmodule

// ===== tb/sd_spi_command_sequencer_core_tb.sv =====
module sd_spi_command_sequencer_core_tb;

    localparam logic [1:0] RESP_UNSET = 2'd0;
    localparam int         IDLE_LIMIT = 1000;
    localparam int         PHASES     = 6;
    localparam int         PHASE_ITEMS = 130;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        poll_limit_we = 1'b0;
    logic [7:0]  poll_limit_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [5:0] cmd_index, [37:6] argument, [39:38] response_type,
    // [40] keep_cs_low, [48:41] miso_byte, [55:49] zero
    logic [55:0] s_tdata = '0;
    // [0] opcode
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] mosi_byte, [8] cs_level, [24:9] response, [31:25] zero
    logic [31:0] m_tdata;
    // [0] send_valid, [1] done_res
    logic [1:0]  m_tuser;

    // sequencer shadow state
    logic [sdspi_pkg::PHASE_W-1:0] seq_phase = sdspi_pkg::PH_IDLE;
    logic [2:0]         arg_pos = 3'd0;
    logic [7:0]         poll_cnt = 8'd0;
    logic [5:0]         cmd_idx = 6'd0;
    logic [31:0]        cmd_arg = 32'd0;
    logic [1:0]         resp_kind = sdspi_pkg::RESP_R1;
    logic               hold_cs = 1'b0;
    logic [15:0]        resp_word = sdspi_pkg::RESP_NONE;
    logic               cs_line = 1'b1;
    logic [7:0]         poll_limit_model = sdspi_pkg::POLL_LIMIT_RST;

    sdspi_pkg::item_t   spi_requests[$];
    sdspi_pkg::result_t sequencer_replies[$];
    sdspi_pkg::item_t   on_bus;
    int      gap_left = 0;
    int      stall_left = 0;
    int      idle_cycles = 0;
    int      mismatch_count = 0;
    bit      no_gaps = 1'b0;

    sd_spi_command_sequencer_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .poll_limit_we    (poll_limit_we),
        .poll_limit_wdata (poll_limit_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic sdspi_pkg::item_t start_req(input logic [5:0] idx,
                                                   input logic [31:0] arg,
                                                   input logic [1:0] kind,
                                                   input logic keep);
        sdspi_pkg::item_t req;
        req.opcode        = sdspi_pkg::OP_START;
        req.cmd_index     = idx;
        req.argument      = arg;
        req.response_type = kind;
        req.keep_cs_low   = keep;
        req.miso_byte     = 8'($urandom);
        return req;
    endfunction

    // unused fields of an exchange report carry noise
    function automatic sdspi_pkg::item_t exch_req(input logic [7:0] miso);
        sdspi_pkg::item_t req;
        req.opcode        = sdspi_pkg::OP_EXCHANGE;
        req.cmd_index     = 6'($urandom);
        req.argument      = $urandom;
        req.response_type = 2'($urandom);
        req.keep_cs_low   = 1'($urandom);
        req.miso_byte     = miso;
        return req;
    endfunction

    // advance the shadow sequencer by one request and return the reply it owes
    function automatic sdspi_pkg::result_t sequence_next_byte(input sdspi_pkg::item_t req);
        sdspi_pkg::result_t reply;
        logic       send;
        logic       done;
        logic       resolved;
        logic       to_trail;
        logic [7:0] mosi;
        send     = 1'b1;
        done     = 1'b0;
        resolved = 1'b0;
        to_trail = 1'b0;
        mosi     = sdspi_pkg::FILL_BYTE;
        if (req.opcode == sdspi_pkg::OP_START) begin
            cmd_idx   = req.cmd_index;
            cmd_arg   = req.argument;
            resp_kind = req.response_type;
            hold_cs   = req.keep_cs_low;
            arg_pos   = 3'd0;
            poll_cnt  = 8'd0;
            resp_word = sdspi_pkg::RESP_NONE;
            cs_line   = 1'b0;
            seq_phase = sdspi_pkg::PH_CMD;
            mosi      = sdspi_pkg::CMD_PREFIX | {2'b00, cmd_idx};
        end else begin
            case (seq_phase)
                sdspi_pkg::PH_CMD: begin
                    arg_pos   = 3'd0;
                    seq_phase = sdspi_pkg::PH_ARG;
                    mosi      = cmd_arg[31:24];
                end
                sdspi_pkg::PH_ARG: begin
                    if (arg_pos < 3'd3) begin
                        arg_pos = arg_pos + 3'd1;
                        mosi    = cmd_arg[(3 - arg_pos) * 8 +: 8];
                    end else begin
                        seq_phase = sdspi_pkg::PH_CRC;
                        mosi      = (cmd_idx == 6'd0) ? sdspi_pkg::CRC_CMD0
                                                      : sdspi_pkg::FILL_BYTE;
                    end
                end
                sdspi_pkg::PH_CRC: seq_phase = sdspi_pkg::PH_FILL;
                sdspi_pkg::PH_FILL: begin
                    if (resp_kind == sdspi_pkg::RESP_R2) begin
                        seq_phase = sdspi_pkg::PH_R2A;
                    end else begin
                        poll_cnt  = 8'd1;
                        seq_phase = sdspi_pkg::PH_R1;
                    end
                end
                sdspi_pkg::PH_R1: begin
                    if (req.miso_byte != sdspi_pkg::FILL_BYTE) begin
                        resp_word = sdspi_pkg::R1_PREFIX | {8'h00, req.miso_byte};
                        resolved  = 1'b1;
                    end else if (poll_cnt >= poll_limit_model) begin
                        resp_word = sdspi_pkg::RESP_NONE;
                        resolved  = 1'b1;
                    end else begin
                        poll_cnt = poll_cnt + 8'd1;
                    end
                end
                sdspi_pkg::PH_BUSY: begin
                    if (req.miso_byte != 8'h00 || poll_cnt >= poll_limit_model) begin
                        to_trail = 1'b1;
                    end else begin
                        poll_cnt = poll_cnt + 8'd1;
                    end
                end
                sdspi_pkg::PH_R2A: begin
                    resp_word = {req.miso_byte, 8'h00};
                    seq_phase = sdspi_pkg::PH_R2B;
                end
                sdspi_pkg::PH_R2B: begin
                    resp_word[7:0] = req.miso_byte;
                    to_trail       = 1'b1;
                end
                sdspi_pkg::PH_TRAIL: begin
                    seq_phase = sdspi_pkg::PH_IDLE;
                    send      = 1'b0;
                    done      = 1'b1;
                end
                default: begin
                    seq_phase = sdspi_pkg::PH_IDLE;
                    send      = 1'b0;
                end
            endcase
        end
        if (resolved) begin
            if (resp_kind == sdspi_pkg::RESP_R1B) begin
                poll_cnt  = 8'd1;
                seq_phase = sdspi_pkg::PH_BUSY;
            end else begin
                to_trail = 1'b1;
            end
        end
        if (to_trail) begin
            if (!hold_cs) cs_line = 1'b1;
            seq_phase = sdspi_pkg::PH_TRAIL;
        end
        reply.send_valid = send;
        reply.mosi_byte  = send ? mosi : 8'h00;
        reply.cs_level   = cs_line;
        reply.done_res   = done;
        reply.response   = done ? resp_word : 16'h0000;
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40)
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // one command sequence with random content; now and then cut short
    task automatic queue_command(output int n_items);
        sdspi_pkg::item_t seq[$];
        logic [1:0] kind;
        int         eff_limit;
        int         cut;
        int         k;
        kind      = 2'($urandom);
        eff_limit = (poll_limit_model == 8'd0) ? 1 : int'(poll_limit_model);
        seq.push_back(start_req(($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom),
                                $urandom, kind, 1'($urandom)));
        repeat (7) seq.push_back(exch_req(8'($urandom)));
        if (kind == sdspi_pkg::RESP_R2) begin
            repeat (2) seq.push_back(exch_req(8'($urandom)));
        end else begin
            if ($urandom_range(0, 7) == 0) begin
                repeat (eff_limit) seq.push_back(exch_req(sdspi_pkg::FILL_BYTE));
            end else begin
                repeat ($urandom_range(0, 3)) seq.push_back(exch_req(sdspi_pkg::FILL_BYTE));
                seq.push_back(exch_req(8'($urandom_range(0, 254))));
            end
            if (kind == sdspi_pkg::RESP_R1B) begin
                if ($urandom_range(0, 7) == 0) begin
                    repeat (eff_limit) seq.push_back(exch_req(8'h00));
                end else begin
                    repeat ($urandom_range(0, 3)) seq.push_back(exch_req(8'h00));
                    seq.push_back(exch_req(8'($urandom_range(1, 255))));
                end
            end
        end
        seq.push_back(exch_req(8'($urandom)));
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (k = 0; k < cut; k++) spi_requests.push_back(seq[k]);
        n_items = cut;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (spi_requests.size() != 0 || s_tvalid || sequencer_replies.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_poll_limit(input logic [7:0] value);
        @(posedge aclk);
        poll_limit_we    <= 1'b1;
        poll_limit_wdata <= value;
        @(posedge aclk);
        poll_limit_we    <= 1'b0;
        poll_limit_model = value;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) sequencer_replies.push_back(sequence_next_byte(on_bus));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (spi_requests.size() != 0) begin
                    on_bus = spi_requests.pop_front();
                    s_tdata  <= {7'd0, on_bus.miso_byte, on_bus.keep_cs_low,
                                 on_bus.response_type, on_bus.argument, on_bus.cmd_index};
                    s_tuser  <= on_bus.opcode;
                    s_tvalid <= 1'b1;
                    gap_left = pick_idle();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        sdspi_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sequencer_replies.size() == 0) begin
                report_mismatch("reply with no request waiting", m_tdata, 32'd0);
            end else begin
                want = sequencer_replies.pop_front();
                if (m_tuser[0] !== want.send_valid)
                    report_mismatch("send_valid", 32'(m_tuser[0]), 32'(want.send_valid));
                if (m_tdata[7:0] !== want.mosi_byte)
                    report_mismatch("mosi_byte", 32'(m_tdata[7:0]), 32'(want.mosi_byte));
                if (m_tdata[8] !== want.cs_level)
                    report_mismatch("cs_level", 32'(m_tdata[8]), 32'(want.cs_level));
                if (m_tuser[1] !== want.done_res)
                    report_mismatch("done_res", 32'(m_tuser[1]), 32'(want.done_res));
                if (m_tdata[24:9] !== want.response)
                    report_mismatch("response", 32'(m_tdata[24:9]), 32'(want.response));
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_idle();
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] limit_plan [PHASES];
        int         n;
        int         got;
        int         p;
        limit_plan = '{8'd1, 8'd255, 8'd0, 8'd5, 8'd2, 8'($urandom_range(3, 20))};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // exchange report with no command running
        spi_requests.push_back(exch_req(8'h00));
        // CMD0, zero argument, unset response type, answered at the first poll
        spi_requests.push_back(start_req(6'd0, 32'h0000_0000, RESP_UNSET, 1'b0));
        repeat (7) spi_requests.push_back(exch_req(sdspi_pkg::FILL_BYTE));
        spi_requests.push_back(exch_req(8'h00));
        spi_requests.push_back(exch_req(sdspi_pkg::FILL_BYTE));
        // R2 with chip select held, abandoned by a new start
        spi_requests.push_back(start_req(6'd63, 32'hFFFF_FFFF, sdspi_pkg::RESP_R2, 1'b1));
        repeat (3) spi_requests.push_back(exch_req(8'hFF));
        // R1b: response byte, one busy byte, then busy end
        spi_requests.push_back(start_req(6'd12, 32'hA5C3_0F96, sdspi_pkg::RESP_R1B, 1'b1));
        repeat (7) spi_requests.push_back(exch_req(sdspi_pkg::FILL_BYTE));
        spi_requests.push_back(exch_req(8'hFE));
        spi_requests.push_back(exch_req(8'h00));
        spi_requests.push_back(exch_req(8'hFF));
        spi_requests.push_back(exch_req(8'h5A));
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            set_poll_limit(limit_plan[p]);
            no_gaps = (p == 3);
            n = 0;
            while (n < PHASE_ITEMS) begin
                // stray exchange reports, mostly landing while idle
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3)) spi_requests.push_back(exch_req(8'($urandom)));
                queue_command(got);
                n += got;
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
